@@ hw/rtl/bhsc_pkg.sv @@
// Shared types, constants and helpers for the boot health soak confirmation block.
package bhsc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CNT_OUT_W   = 16;
    localparam int TIME_W      = 64;
    localparam int SOAK_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [SOAK_W-1:0] SOAK_MS_RESET = SOAK_W'(60000);

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARMED      = 2'd0,
        CFG_SOAK_MS    = 2'd1,
        CFG_START_TIME = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              clk_tree_ok;
        logic              flash_ok;
        logic              wdt_ok;
        logic              peripherals_ok;
        logic              partner_ok;
        logic              image_authentic;
        logic              commit_ok;
    } tick_t;

    typedef struct packed {
        logic                 confirmed_now;
        logic                 commit_attempted;
        logic                 is_confirmed;
        logic                 fault_latched;
        logic                 soak_running;
        logic [CNT_OUT_W-1:0] clock_fault_count;
        logic [CNT_OUT_W-1:0] interrupted_count;
    } result_t;

    typedef struct packed {
        logic step;   // apply the registered tick to the kept state
        logic clear;  // armed was written: reload all kept state
    } core_ctrl_t;

    localparam count_t CNT_MAX = {COUNT_WIDTH{1'b1}};

    function automatic count_t sat_inc(input count_t c);
        return (c == CNT_MAX) ? c : c + count_t'(1);
    endfunction

    // Low bits of a counter as carried on the result word, zero-extended if narrower.
    function automatic logic [CNT_OUT_W-1:0] cnt_out(input count_t c);
        logic [CNT_OUT_W+COUNT_WIDTH-1:0] wide;
        wide = {{CNT_OUT_W{1'b0}}, c};
        return wide[CNT_OUT_W-1:0];
    endfunction

endpackage

@@ hw/rtl/bhsc_core.sv @@
// Kept soak state and the single-pass update for one tick.
module bhsc_core import bhsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  core_ctrl_t            ctrl,
    input  logic                  armed,
    input  logic [SOAK_W-1:0]     soak_ms,
    input  logic [TIME_W-1:0]     start_time_ms,
    input  tick_t                 tick,
    output result_t               result
);

    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic [TIME_W-1:0] healthy_since_reg, healthy_since_next;
    logic              soak_active_reg, soak_active_next;
    logic              done_reg, done_next;
    logic              fault_reg, fault_next;
    count_t            clock_faults_reg, clock_faults_next;
    count_t            interrupted_reg, interrupted_next;

    logic              healthy;
    logic              confirmed_now;
    logic              attempted;
    logic [TIME_W-1:0] elapsed;

    assign healthy = tick.clk_tree_ok & tick.flash_ok & tick.wdt_ok &
                     tick.peripherals_ok & tick.partner_ok & tick.image_authentic;
    assign elapsed = tick.now_ms - healthy_since_reg;

    always_comb begin
        last_time_next     = last_time_reg;
        healthy_since_next = healthy_since_reg;
        soak_active_next   = soak_active_reg;
        done_next          = done_reg;
        fault_next         = fault_reg;
        clock_faults_next  = clock_faults_reg;
        interrupted_next   = interrupted_reg;
        confirmed_now      = 1'b0;
        attempted          = 1'b0;
        if (armed && !done_reg && !fault_reg) begin
            last_time_next = tick.now_ms;
            if (tick.now_ms < last_time_reg) begin
                clock_faults_next = sat_inc(clock_faults_reg);
                soak_active_next  = 1'b0;
            end else if (!healthy) begin
                if (soak_active_reg) begin
                    interrupted_next = sat_inc(interrupted_reg);
                end
                soak_active_next = 1'b0;
            end else if (!soak_active_reg) begin
                soak_active_next   = 1'b1;
                healthy_since_next = tick.now_ms;
            end else if (elapsed >= {{(TIME_W-SOAK_W){1'b0}}, soak_ms}) begin
                attempted = 1'b1;
                if (tick.commit_ok) begin
                    done_next     = 1'b1;
                    confirmed_now = 1'b1;
                end else begin
                    fault_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        result.confirmed_now     = confirmed_now;
        result.commit_attempted  = attempted;
        result.is_confirmed      = done_next;
        result.fault_latched     = fault_next;
        result.soak_running      = soak_active_next;
        result.clock_fault_count = cnt_out(clock_faults_next);
        result.interrupted_count = cnt_out(interrupted_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg     <= '0;
            healthy_since_reg <= '0;
            soak_active_reg   <= 1'b0;
            done_reg          <= 1'b0;
            fault_reg         <= 1'b0;
            clock_faults_reg  <= '0;
            interrupted_reg   <= '0;
        end else if (ctrl.clear) begin
            last_time_reg     <= start_time_ms;
            healthy_since_reg <= '0;
            soak_active_reg   <= 1'b0;
            done_reg          <= 1'b0;
            fault_reg         <= 1'b0;
            clock_faults_reg  <= '0;
            interrupted_reg   <= '0;
        end else if (ctrl.step) begin
            last_time_reg     <= last_time_next;
            healthy_since_reg <= healthy_since_next;
            soak_active_reg   <= soak_active_next;
            done_reg          <= done_next;
            fault_reg         <= fault_next;
            clock_faults_reg  <= clock_faults_next;
            interrupted_reg   <= interrupted_next;
        end
    end

    // The two latches exclude each other: once one is set no tick reaches the other.
    a_latch_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(done_reg && fault_reg))
        else $error("confirmed and fault latched together");

    // A latched block ignores ticks until armed is written again.
    a_latched_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step && !ctrl.clear && (done_reg || fault_reg)) |=>
            $stable(last_time_reg) && $stable(clock_faults_reg))
        else $error("latched block changed state on a tick");

    // Arming write clears the kept state.
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |=> !soak_active_reg && !done_reg && !fault_reg &&
            (clock_faults_reg == '0) && (interrupted_reg == '0))
        else $error("kept state not cleared by armed write");

endmodule

@@ hw/rtl/boot_health_soak_confirm_top.sv @@
// Top level of the boot health soak confirmation block: handshakes, config and result registers.
// A word taken on s_ passes through the input register, then the result register, before it shows on m_.
// Throughput: one word per cycle while m_ takes each result; the compare-and-update on the kept state is combinational.
// While a result waits on m_, one more word is taken into an empty input register, then s_ready
// stays low until m_ takes the waiting result.
// Reset (aresetn low, synchronous): not armed, soak_ms 60000, start_time_ms 0, all kept state clear.
// Configuration is accepted in every cycle; a write to armed clears the kept state.
module boot_health_soak_confirm_top import bhsc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tick_t                  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output result_t                m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                 armed_reg;
    logic [SOAK_W-1:0]    soak_ms_reg;
    logic [TIME_W-1:0]    start_time_reg;

    logic                 in_valid_reg;
    tick_t                in_data_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;

    logic                 out_free;
    logic                 cfg_write;
    core_ctrl_t           ctrl;
    result_t              result;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign out_free   = !out_valid_reg || m_ready;
    assign ctrl.step  = in_valid_reg && out_free;
    assign ctrl.clear = cfg_write && (cfg_index_t'(cfg_index) == CFG_ARMED);
    assign s_ready    = !in_valid_reg || out_free;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg      <= 1'b0;
            soak_ms_reg    <= SOAK_MS_RESET;
            start_time_reg <= '0;
        end else if (cfg_write) begin
            case (cfg_index_t'(cfg_index))
                CFG_ARMED:      armed_reg      <= cfg_data[0];
                CFG_SOAK_MS:    soak_ms_reg    <= cfg_data[SOAK_W-1:0];
                CFG_START_TIME: start_time_reg <= cfg_data[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (ctrl.step) begin
            out_data_reg <= result;
        end
    end

    bhsc_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .armed         (armed_reg),
        .soak_ms       (soak_ms_reg),
        .start_time_ms (start_time_reg),
        .tick          (in_data_reg),
        .result        (result)
    );

    // A confirming word must also report the commit and the latched flag.
    a_confirm_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.confirmed_now) |->
            (out_data_reg.commit_attempted && out_data_reg.is_confirmed))
        else $error("confirming word without commit or latch");

    // A word held at the output is never overwritten by the next update.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> ($stable(out_data_reg) && out_valid_reg))
        else $error("pending result word overwritten");

    // An accepted input word is held in the input register on the next cycle.
    a_in_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted word lost from input register");

endmodule
